[rtl/lcrl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcrl_pkg
// Shared widths and result status codes of the longest consecutive run unit.
// ----------------------------------------------------------------------------
package lcrl_pkg;

    localparam int VALUE_W = 32;
    localparam int RUN_W   = 5;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_SIZE  = 2'd2
    } status_t;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic        [RUN_W-1:0]   run_t;

endpackage

[rtl/longest_consecutive_run_length_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_consecutive_run_length_unit
// Loads a set of signed values into a sorted store by insertion and, after the
// request marked last, scans the store for the longest run of +1 steps.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An element is placed
// by walking the store downwards from the top, one read and one write of the
// store per cycle, so a request that carries an element keeps busy high while
// each stored element greater than it moves up one entry, and then while it is
// written into the gap; a request into a full store, or one without an
// element, does not walk the store.
// A request marked last adds a classification state and, for a non-empty
// set without overflow, a scan over the n stored elements.
// The result shows on status and run_length for exactly one cycle with done
// high; the receiver cannot stall it, and busy is low in that cycle. The store
// needs no clearing after reset: only entries below the element count are read.
// ----------------------------------------------------------------------------
module longest_consecutive_run_length_unit #(
    parameter int MAX_ELEMENTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              has_value,
    input  lcrl_pkg::value_t  value,
    input  logic              last,
    output logic              done,
    output lcrl_pkg::status_t status,
    output lcrl_pkg::run_t    run_length
);
    import lcrl_pkg::*;

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_DECIDE,
        S_SCAN0,
        S_SCAN
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic [AW-1:0]   j_reg, j_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   run_reg, run_next;
    logic [CW-1:0]   best_reg, best_next;
    value_t          v_reg, v_next;
    value_t          prev_reg, prev_next;
    logic            last_reg, last_next;
    logic            done_reg, done_next;
    status_t         status_reg, status_next;
    run_t            rl_reg, rl_next;

    value_t          store_mem [MAX_ELEMENTS];
    value_t          rdata_reg;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    value_t          wr_data;

    logic signed [VALUE_W:0] diff;
    logic [CW-1:0]           run_inc;

    assign diff    = {rdata_reg[VALUE_W-1], rdata_reg} - {prev_reg[VALUE_W-1], prev_reg};
    assign run_inc = run_reg + CW'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= store_mem[rd_addr];
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        j_next      = j_reg;
        i_next      = i_reg;
        run_next    = run_reg;
        best_next   = best_reg;
        v_next      = v_reg;
        prev_next   = prev_reg;
        last_next   = last_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rl_next     = rl_reg;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = j_reg;
        wr_data     = v_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    v_next    = value;
                    last_next = last;
                    j_next    = count_reg[AW-1:0];
                    if (has_value && (count_reg == CW'(MAX_ELEMENTS)))
                    begin
                        ovf_next   = 1'b1;
                        state_next = last ? S_DECIDE : S_IDLE;
                    end
                    else if (has_value && (count_reg == '0))
                    begin
                        state_next = S_PUT;
                    end
                    else if (has_value)
                    begin
                        rd_addr    = AW'(count_reg - CW'(1));
                        state_next = S_INS;
                    end
                    else
                    begin
                        state_next = last ? S_DECIDE : S_IDLE;
                    end
                end
            end
            S_INS:
            begin
                // rdata holds the entry just below the gap at j
                if (rdata_reg > v_reg)
                begin
                    wr_en   = 1'b1;
                    wr_data = rdata_reg;
                    j_next  = j_reg - AW'(1);
                    if (j_reg == AW'(1))
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        rd_addr = j_reg - AW'(2);
                    end
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = last_reg ? S_DECIDE : S_IDLE;
            end
            S_DECIDE:
            begin
                if (ovf_reg || (count_reg == '0))
                begin
                    done_next   = 1'b1;
                    status_next = ovf_reg ? ST_SIZE : ST_EMPTY;
                    rl_next     = '0;
                    count_next  = '0;
                    ovf_next    = 1'b0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN0;
                end
            end
            S_SCAN0:
            begin
                rd_addr    = '0;
                i_next     = CW'(1);
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // rdata holds entry i - 1
                if (i_reg == CW'(1))
                begin
                    run_next  = CW'(1);
                    best_next = CW'(1);
                end
                else if (diff == '0)
                begin
                    run_next = run_reg;
                end
                else if (diff == (VALUE_W + 1)'(1))
                begin
                    run_next = run_inc;
                    if (run_inc > best_reg)
                    begin
                        best_next = run_inc;
                    end
                end
                else
                begin
                    run_next = CW'(1);
                end
                prev_next = rdata_reg;
                if (i_reg == count_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    rl_next     = RUN_W'(best_next);
                    count_next  = '0;
                    ovf_next    = 1'b0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    rd_addr = i_reg[AW-1:0];
                    i_next  = i_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg      <= j_next;
        i_reg      <= i_next;
        run_reg    <= run_next;
        best_reg   <= best_next;
        v_reg      <= v_next;
        prev_reg   <= prev_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        rl_reg     <= rl_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign run_length = rl_reg;

endmodule

[rtl/lcrl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcrl_checker
// Port-level checks on the result timing, status codes and error run length of the longest consecutive run unit.
// ----------------------------------------------------------------------------
module lcrl_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              busy,
    input logic              done,
    input lcrl_pkg::status_t status,
    input lcrl_pkg::run_t    run_length
);
    import lcrl_pkg::*;

    // a result frees the unit for the next request
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy high while a result is shown");

    // a result always follows work on a last request
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without preceding work");

    // at most one result per set, never back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results on consecutive cycles");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (run_length == '0))
        else $error("non-zero run length with error status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status == ST_OK) || (status == ST_EMPTY) || (status == ST_SIZE)))
        else $error("unknown status code");

endmodule

bind longest_consecutive_run_length_unit lcrl_checker u_lcrl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .run_length (run_length)
);
